@@ rtl/core/cnvp_pkg.sv @@
package cnvp_pkg;

    // Longest string accepted; a terminator at offset MAX_LEN still ends the parse.
    localparam int MAX_LEN = 4096;
    // Position counter holds 0..MAX_LEN.
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    // Fixed width of the offset fields in a result.
    localparam int OFS_W   = 13;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_EQ   = 8'h3D;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY_NAME = 2'd1,
        ST_BAD_CHAR   = 2'd2,
        ST_TOO_LONG   = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [OFS_W-1:0]   name_end;
        logic [OFS_W-1:0]   value_start;
        logic [OFS_W-1:0]   value_end;
    } result_t;

    // C-locale isspace: HT, LF, VT, FF, CR and space.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

@@ rtl/core/cnvp_engine.sv @@
module cnvp_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  logic [7:0]       ch,
    input  logic             start_req,
    output logic             res_valid,
    output cnvp_pkg::result_t res
);
    import cnvp_pkg::*;

    typedef enum logic [2:0] {
        PH_DONE  = 3'd0,
        PH_NAME  = 3'd1,
        PH_SKIP1 = 3'd2,
        PH_EQ    = 3'd3,
        PH_SKIP2 = 3'd4,
        PH_VALUE = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   ne_reg, ne_next;
    logic [POS_W-1:0]   vs_reg, vs_next;
    logic [POS_W-1:0]   ve_reg, ve_next;

    logic               fin;
    logic               term;
    logic               ws;
    logic [POS_W-1:0]   p;
    status_t            st;
    logic [POS_W-1:0]   r_ne, r_vs, r_ve;

    // One byte of the parse, phases fall through in order within the byte.
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        ne_next    = ne_reg;
        vs_next    = vs_reg;
        ve_next    = ve_reg;
        fin        = 1'b0;
        st         = ST_OK;
        r_ne       = '0;
        r_vs       = '0;
        r_ve       = '0;
        ws         = is_ws(ch);
        term       = (ch == CH_SEMI) || (ch == CH_EQ) || (ch == CH_NUL) || ws;

        if (start_req) begin
            phase_next = PH_NAME;
            pos_next   = '0;
            ne_next    = '0;
            vs_next    = '0;
            ve_next    = '0;
        end
        p = pos_next;

        if (phase_next != PH_DONE) begin
            if (phase_next == PH_NAME && term) begin
                if (p == '0) begin
                    fin = 1'b1;
                    st  = ST_EMPTY_NAME;
                end else begin
                    ne_next    = p;
                    phase_next = PH_SKIP1;
                end
            end
            if (!fin) begin
                if (phase_next == PH_SKIP1) begin
                    if (ch == CH_NUL || ch == CH_SEMI) begin
                        fin  = 1'b1;
                        st   = ST_OK;
                        r_ne = ne_next;
                        r_vs = p;
                        r_ve = p;
                    end else if (ch == CH_EQ) begin
                        phase_next = PH_EQ;
                    end else if (!ws) begin
                        fin  = 1'b1;
                        st   = ST_BAD_CHAR;
                        r_ne = ne_next;
                    end
                end else if (phase_next == PH_EQ) begin
                    if (ch != CH_EQ) phase_next = PH_SKIP2;
                end
            end
            if (!fin && phase_next == PH_SKIP2 && !ws) begin
                vs_next    = p;
                ve_next    = p;
                phase_next = PH_VALUE;
            end
            if (!fin && phase_next == PH_VALUE) begin
                if (ch == CH_NUL || ch == CH_SEMI) begin
                    fin  = 1'b1;
                    st   = ST_OK;
                    r_ne = ne_next;
                    r_vs = vs_next;
                    r_ve = ve_next;
                end else if (!ws) begin
                    ve_next = p + POS_W'(1);
                end
            end
            if (!fin) begin
                if (p >= POS_W'(MAX_LEN)) begin
                    fin = 1'b1;
                    st  = ST_TOO_LONG;
                end else begin
                    pos_next = p + POS_W'(1);
                end
            end
            if (fin) phase_next = PH_DONE;
        end
    end

    assign res_valid       = item_valid && fin;
    assign res.status      = st;
    assign res.name_end    = OFS_W'(r_ne);
    assign res.value_start = OFS_W'(r_vs);
    assign res.value_end   = OFS_W'(r_ve);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
            pos_reg   <= '0;
            ne_reg    <= '0;
            vs_reg    <= '0;
            ve_reg    <= '0;
        end else if (item_valid) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ne_reg    <= ne_next;
            vs_reg    <= vs_next;
            ve_reg    <= ve_next;
        end
    end

endmodule

@@ rtl/core/cnvp_out_buf.sv @@
module cnvp_out_buf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  cnvp_pkg::result_t       load_data,
    output logic                    free,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [cnvp_pkg::OFS_W-1:0] m_name_end,
    output logic [cnvp_pkg::OFS_W-1:0] m_value_start,
    output logic [cnvp_pkg::OFS_W-1:0] m_value_end
);
    import cnvp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Slot can take a new result when empty or draining this cycle.
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid       = valid_reg;
    assign m_status      = data_reg.status;
    assign m_name_end    = data_reg.name_end;
    assign m_value_start = data_reg.value_start;
    assign m_value_end   = data_reg.value_end;

endmodule

@@ rtl/core/cookie_name_value_parser_top.sv @@
// Cookie name/value parser. Feed the bytes of a cookie string one per transfer
// on s_ch, with s_start_req high on the first byte of each string (offset 0);
// a start always abandons any parse in progress. For each string that is not
// abandoned, exactly one result transfer appears on the m_ side: m_status (0
// ok, 1 empty name, 2 junk after the name, 3 too long) with the name end,
// value start and value end offsets of the first "name [= value]" pair. Error
// results carry zero for the offsets they do not define. Bytes after the
// result, and bytes with no start seen since reset, are dropped. A byte is
// taken every cycle while the result slot is free: the per-byte parse step is
// combinational logic between the input register and the result register,
// which takes the result of the byte that ends the string, raising m_valid.
// With the result slot full and m_ready low, one more byte is taken into the
// input register before s_ready drops.
module cookie_name_value_parser_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_ch,
    input  logic                        s_start_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [cnvp_pkg::OFS_W-1:0]  m_name_end,
    output logic [cnvp_pkg::OFS_W-1:0]  m_value_start,
    output logic [cnvp_pkg::OFS_W-1:0]  m_value_end
);
    import cnvp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       start_reg;

    logic       out_free;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // The held byte moves through the parse step only when the result slot
    // can take whatever it produces.
    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg    <= s_ch;
            start_reg <= s_start_req;
        end
    end

    cnvp_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .ch         (ch_reg),
        .start_req  (start_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    cnvp_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (res_valid),
        .load_data     (res),
        .free          (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_name_end    (m_name_end),
        .m_value_start (m_value_start),
        .m_value_end   (m_value_end)
    );

endmodule

@@ rtl/core/cnvp_checker.sv @@
module cnvp_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [7:0]                  s_ch,
    input  logic                        s_start_req,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [1:0]                  m_status,
    input  logic [cnvp_pkg::OFS_W-1:0]  m_name_end,
    input  logic [cnvp_pkg::OFS_W-1:0]  m_value_start,
    input  logic [cnvp_pkg::OFS_W-1:0]  m_value_end
);
    import cnvp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_name_end)
            && $stable(m_value_start) && $stable(m_value_end))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY_NAME |->
            m_name_end == '0 && m_value_start == '0 && m_value_end == '0)
        else $error("empty name result with nonzero offsets");

    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_BAD_CHAR |->
            m_name_end != '0 && m_value_start == '0 && m_value_end == '0)
        else $error("bad char result offsets wrong");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |->
            m_name_end != '0 && m_value_start >= m_name_end && m_value_end >= m_value_start)
        else $error("ok result offsets out of order");

endmodule

bind cookie_name_value_parser_top cnvp_checker u_cnvp_checker (.*);
